FILE: rtl/asgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types and codes for the SGR transcript writer: controller commands,
// byte classes, result kinds, byte values and attribute bits.
// ----------------------------------------------------------------------------
package asgr_pkg;

    // Datapath operations issued by the controller
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE        = 4'd0;
    localparam op_t OP_SILENT      = 4'd1;
    localparam op_t OP_SGR_START   = 4'd2;
    localparam op_t OP_SGR_STEP    = 4'd3;
    localparam op_t OP_PATH_BYTE   = 4'd4;
    localparam op_t OP_PATH_DONE   = 4'd5;
    localparam op_t OP_NEW_ROW     = 4'd6;
    localparam op_t OP_CLEAR_ALL   = 4'd7;
    localparam op_t OP_BACKSPACE   = 4'd8;
    localparam op_t OP_PUT         = 4'd9;
    localparam op_t OP_EOL         = 4'd10;

    // Class of the held byte, as seen against the current parser state
    typedef logic [3:0] cls_t;
    localparam cls_t CLS_SILENT    = 4'd0;
    localparam cls_t CLS_SGR       = 4'd1;
    localparam cls_t CLS_PATH_BYTE = 4'd2;
    localparam cls_t CLS_PATH_DONE = 4'd3;
    localparam cls_t CLS_NEWLINE   = 4'd4;
    localparam cls_t CLS_TAB       = 4'd5;
    localparam cls_t CLS_CLEAR     = 4'd6;
    localparam cls_t CLS_BACKSPACE = 4'd7;
    localparam cls_t CLS_PRINT     = 4'd8;

    typedef struct packed {
        op_t  op;
        logic last;    // final result of this byte
        logic blank;   // tab fill cell: space, attribute zero
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic out_free;     // output register can take a result this cycle
        logic col_lt_lim;   // cursor below the column limit
        logic col_aligned;  // cursor on a tab stop
        logic sgr_last;     // parameter walk at its last entry
    } sts_t;

    // Result kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_PUT       = 3'd0;
    localparam kind_t KIND_EOL       = 3'd1;
    localparam kind_t KIND_NEW_ROW   = 3'd2;
    localparam kind_t KIND_CLEAR     = 3'd3;
    localparam kind_t KIND_PATH_BYTE = 3'd4;
    localparam kind_t KIND_PATH_DONE = 3'd5;

    // Escape parser phases
    typedef logic [1:0] phase_t;
    localparam phase_t PH_PLAIN = 2'd0;
    localparam phase_t PH_ESC   = 2'd1;
    localparam phase_t PH_CSI   = 2'd2;

    // Byte values
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_FF       = 8'h0C;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_MARK     = 8'h10;
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SGR_M    = 8'h6D;
    localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

    // SGR parameter codes
    localparam logic [7:0] SGR_RESET    = 8'd0;
    localparam logic [7:0] SGR_BOLD     = 8'd1;
    localparam logic [7:0] SGR_NORMAL   = 8'd22;
    localparam logic [7:0] SGR_FG_LO    = 8'd30;
    localparam logic [7:0] SGR_FG_HI    = 8'd37;
    localparam logic [7:0] SGR_FG_DEF   = 8'd39;
    localparam logic [7:0] SGR_BR_LO    = 8'd90;
    localparam logic [7:0] SGR_BR_HI    = 8'd97;
    localparam logic [7:0] SGR_FG_BASE  = 8'd29;
    localparam logic [7:0] SGR_BR_BASE  = 8'd89;
    localparam logic [7:0] PARAM_MAX    = 8'd255;

    localparam logic [5:0] ATTR_BOLD    = 6'h20;
    localparam logic [5:0] ATTR_BRIGHT  = 6'h10;

    localparam logic [7:0] MIN_COLUMNS  = 8'd20;
    localparam logic [7:0] COLS_RESET   = 8'd96;
    localparam int         TAB_BITS     = 3;

endpackage

`default_nettype wire

FILE: rtl/asgr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_ctrl
// Sequencer for one input byte: decodes the byte class, then steps the
// datapath through the results it causes or through the SGR parameter walk.
// ----------------------------------------------------------------------------
module asgr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    output logic               in_ready,
    input  wire asgr_pkg::sts_t sts,
    output asgr_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_TAB_FIRST = 3'd2;
    localparam logic [2:0] S_TAB       = 3'd3;
    localparam logic [2:0] S_PUT       = 3'd4;
    localparam logic [2:0] S_EOL       = 3'd5;
    localparam logic [2:0] S_SGR       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = asgr_pkg::OP_NONE;
        cmd.last   = 1'b0;
        cmd.blank  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cls)
                    asgr_pkg::CLS_SILENT:
                    begin
                        cmd.op     = asgr_pkg::OP_SILENT;
                        state_next = S_IDLE;
                    end
                    asgr_pkg::CLS_SGR:
                    begin
                        cmd.op     = asgr_pkg::OP_SGR_START;
                        state_next = S_SGR;
                    end
                    asgr_pkg::CLS_PATH_BYTE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.op     = asgr_pkg::OP_PATH_BYTE;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    asgr_pkg::CLS_PATH_DONE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.op     = asgr_pkg::OP_PATH_DONE;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    asgr_pkg::CLS_NEWLINE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.op     = asgr_pkg::OP_NEW_ROW;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    asgr_pkg::CLS_CLEAR:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.op     = asgr_pkg::OP_CLEAR_ALL;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    asgr_pkg::CLS_BACKSPACE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.op     = asgr_pkg::OP_BACKSPACE;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    asgr_pkg::CLS_TAB:
                    begin
                        state_next = S_TAB_FIRST;
                    end
                    asgr_pkg::CLS_PRINT:
                    begin
                        // hard wrap: open a new row before the cell
                        if (!sts.col_lt_lim)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.op     = asgr_pkg::OP_NEW_ROW;
                                state_next = S_PUT;
                            end
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TAB_FIRST:
            begin
                if (!sts.col_lt_lim)
                begin
                    state_next = S_EOL;
                end
                else if (sts.out_free)
                begin
                    cmd.op     = asgr_pkg::OP_PUT;
                    cmd.blank  = 1'b1;
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                if (!sts.col_lt_lim || sts.col_aligned)
                begin
                    state_next = S_EOL;
                end
                else if (sts.out_free)
                begin
                    cmd.op    = asgr_pkg::OP_PUT;
                    cmd.blank = 1'b1;
                end
            end
            S_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = asgr_pkg::OP_PUT;
                    state_next = S_EOL;
                end
            end
            S_EOL:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = asgr_pkg::OP_EOL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SGR:
            begin
                cmd.op = asgr_pkg::OP_SGR_STEP;
                if (sts.sgr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/asgr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_dp
// Parser and ring state, SGR parameter store, column limit register and the
// output register that holds one result beat.
// ----------------------------------------------------------------------------
module asgr_dp #(
    parameter int RING_ROWS   = 256,
    parameter int MAX_COLUMNS = 220,
    parameter int PATH_BYTES  = 192,
    parameter int SGR_SLOTS   = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic [7:0]     in_byte,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_data,
    input  wire asgr_pkg::cmd_t cmd,
    output asgr_pkg::sts_t      sts,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [47:0]         out_data,
    output logic [2:0]          out_user,
    output logic                out_last
);

    localparam int HEAD_W    = $clog2(RING_ROWS);
    localparam int LIVE_W    = $clog2(RING_ROWS + 1);
    localparam int PATH_W    = $clog2(PATH_BYTES);
    localparam int CNT_W     = $clog2(SGR_SLOTS + 1);
    localparam int IDX_W     = (SGR_SLOTS > 1) ? $clog2(SGR_SLOTS) : 1;
    localparam int ROW_EXT_W = (HEAD_W > 8) ? HEAD_W : 8;
    localparam int LIV_EXT_W = (LIVE_W > 9) ? LIVE_W : 9;

    logic [7:0]              byte_reg;
    logic [7:0]              cols_reg;
    asgr_pkg::phase_t        phase_reg;
    logic [7:0]              param_store [SGR_SLOTS];
    logic [CNT_W-1:0]        pcount_reg;
    logic [7:0]              pvalue_reg;
    logic                    ppend_reg;
    logic [IDX_W-1:0]        sidx_reg;
    logic [5:0]              attr_reg;
    logic [HEAD_W-1:0]       head_reg;
    logic [LIVE_W-1:0]       live_reg;
    logic [7:0]              col_reg;
    logic                    capt_reg;
    logic [PATH_W-1:0]       plen_reg;

    logic                    out_valid_reg;
    logic [47:0]             out_data_reg;
    logic [2:0]              out_user_reg;
    logic                    out_last_reg;

    logic [7:0]              lim;
    logic                    is_digit;
    logic                    is_final;
    logic [11:0]             digit_acc;
    logic [7:0]              digit_sat;
    logic                    slot_free;
    logic                    store_we;
    logic [7:0]              store_wdata;
    logic [7:0]              sgr_param;
    logic [7:0]              fg_code;
    logic [7:0]              br_code;
    logic [5:0]              attr_applied;
    logic [HEAD_W-1:0]       head_inc;
    logic [LIVE_W-1:0]       live_inc;
    logic                    emit;
    asgr_pkg::kind_t         e_kind;
    logic [HEAD_W-1:0]       e_row;
    logic [LIVE_W-1:0]       e_live;
    logic [7:0]              e_col;
    logic [7:0]              e_char;
    logic [5:0]              e_attr;
    logic [7:0]              e_idx;
    logic [ROW_EXT_W-1:0]    row_ext;
    logic [LIV_EXT_W-1:0]    live_ext;

    // Column limit clamped into the legal range
    always_comb
    begin
        if (cols_reg < asgr_pkg::MIN_COLUMNS)
        begin
            lim = asgr_pkg::MIN_COLUMNS;
        end
        else if (cols_reg > 8'(MAX_COLUMNS))
        begin
            lim = 8'(MAX_COLUMNS);
        end
        else
        begin
            lim = cols_reg;
        end
    end

    assign is_digit  = (byte_reg >= asgr_pkg::BYTE_DIGIT_0) && (byte_reg <= asgr_pkg::BYTE_DIGIT_9);
    assign is_final  = (byte_reg >= asgr_pkg::BYTE_FINAL_LO) && (byte_reg <= asgr_pkg::BYTE_FINAL_HI);
    assign slot_free = (pcount_reg < CNT_W'(SGR_SLOTS));

    // value * 10 + digit, saturating at 255
    always_comb
    begin
        logic [11:0] base;
        base      = ppend_reg ? {4'd0, pvalue_reg} : 12'd0;
        digit_acc = (base << 3) + (base << 1) + {4'd0, byte_reg - asgr_pkg::BYTE_DIGIT_0};
        digit_sat = (digit_acc > 12'(asgr_pkg::PARAM_MAX)) ? asgr_pkg::PARAM_MAX : digit_acc[7:0];
    end

    // Byte class against the current parser state
    always_comb
    begin
        sts.cls = asgr_pkg::CLS_SILENT;
        if (capt_reg)
        begin
            if (byte_reg == asgr_pkg::BYTE_LF)
            begin
                sts.cls = asgr_pkg::CLS_PATH_DONE;
            end
            else if (plen_reg < PATH_W'(PATH_BYTES - 1))
            begin
                sts.cls = asgr_pkg::CLS_PATH_BYTE;
            end
        end
        else if (byte_reg == asgr_pkg::BYTE_MARK || phase_reg == asgr_pkg::PH_ESC)
        begin
            sts.cls = asgr_pkg::CLS_SILENT;
        end
        else if (phase_reg == asgr_pkg::PH_CSI)
        begin
            if (byte_reg == asgr_pkg::BYTE_SGR_M)
            begin
                sts.cls = asgr_pkg::CLS_SGR;
            end
        end
        else if (byte_reg == asgr_pkg::BYTE_LF)
        begin
            sts.cls = asgr_pkg::CLS_NEWLINE;
        end
        else if (byte_reg == asgr_pkg::BYTE_TAB)
        begin
            sts.cls = asgr_pkg::CLS_TAB;
        end
        else if (byte_reg == asgr_pkg::BYTE_FF)
        begin
            sts.cls = asgr_pkg::CLS_CLEAR;
        end
        else if (byte_reg == asgr_pkg::BYTE_BS)
        begin
            if (col_reg != 8'd0)
            begin
                sts.cls = asgr_pkg::CLS_BACKSPACE;
            end
        end
        else if (byte_reg >= asgr_pkg::BYTE_SPACE)
        begin
            sts.cls = asgr_pkg::CLS_PRINT;
        end
    end

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.col_lt_lim  = (col_reg < lim);
    assign sts.col_aligned = (col_reg[asgr_pkg::TAB_BITS-1:0] == '0);
    assign sts.sgr_last    = (pcount_reg == '0)
                           || (CNT_W'(sidx_reg) == pcount_reg - CNT_W'(1));

    // Parameter store push: on ';' inside CSI, or the pending value at 'm'
    always_comb
    begin
        store_we    = 1'b0;
        store_wdata = ppend_reg ? pvalue_reg : 8'd0;
        if (slot_free)
        begin
            if (cmd.op == asgr_pkg::OP_SILENT && !capt_reg && byte_reg != asgr_pkg::BYTE_MARK
                && phase_reg == asgr_pkg::PH_CSI && byte_reg == asgr_pkg::BYTE_SEMI)
            begin
                store_we = 1'b1;
            end
            if (cmd.op == asgr_pkg::OP_SGR_START && ppend_reg)
            begin
                store_we = 1'b1;
            end
        end
    end

    // Apply one stored SGR parameter to the attribute
    assign sgr_param = param_store[sidx_reg];
    assign fg_code   = sgr_param - asgr_pkg::SGR_FG_BASE;
    assign br_code   = sgr_param - asgr_pkg::SGR_BR_BASE;

    always_comb
    begin
        attr_applied = attr_reg;
        if (sgr_param == asgr_pkg::SGR_RESET)
        begin
            attr_applied = 6'd0;
        end
        else if (sgr_param == asgr_pkg::SGR_BOLD)
        begin
            attr_applied = attr_reg | asgr_pkg::ATTR_BOLD;
        end
        else if (sgr_param == asgr_pkg::SGR_NORMAL)
        begin
            attr_applied = attr_reg & ~asgr_pkg::ATTR_BOLD;
        end
        else if (sgr_param >= asgr_pkg::SGR_FG_LO && sgr_param <= asgr_pkg::SGR_FG_HI)
        begin
            attr_applied = (attr_reg & asgr_pkg::ATTR_BOLD) | {2'b00, fg_code[3:0]};
        end
        else if (sgr_param >= asgr_pkg::SGR_BR_LO && sgr_param <= asgr_pkg::SGR_BR_HI)
        begin
            attr_applied = (attr_reg & asgr_pkg::ATTR_BOLD) | asgr_pkg::ATTR_BRIGHT
                         | {2'b00, br_code[3:0]};
        end
        else if (sgr_param == asgr_pkg::SGR_FG_DEF)
        begin
            attr_applied = attr_reg & asgr_pkg::ATTR_BOLD;
        end
    end

    assign head_inc = (head_reg == HEAD_W'(RING_ROWS - 1)) ? '0 : head_reg + HEAD_W'(1);
    assign live_inc = (live_reg < LIVE_W'(RING_ROWS)) ? live_reg + LIVE_W'(1) : live_reg;

    // Result fields for the issued operation
    always_comb
    begin
        emit   = 1'b0;
        e_kind = asgr_pkg::KIND_PUT;
        e_row  = '0;
        e_live = live_reg;
        e_col  = 8'd0;
        e_char = 8'd0;
        e_attr = 6'd0;
        e_idx  = 8'd0;
        unique case (cmd.op)
            asgr_pkg::OP_PATH_BYTE:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_PATH_BYTE;
                e_char = byte_reg;
                e_idx  = 8'(plen_reg);
            end
            asgr_pkg::OP_PATH_DONE:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_PATH_DONE;
                e_idx  = 8'(plen_reg);
            end
            asgr_pkg::OP_NEW_ROW:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_NEW_ROW;
                e_row  = head_inc;
                e_live = live_inc;
            end
            asgr_pkg::OP_CLEAR_ALL:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_CLEAR;
                e_live = LIVE_W'(1);
            end
            asgr_pkg::OP_BACKSPACE:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_EOL;
                e_row  = head_reg;
                e_col  = col_reg - 8'd1;
            end
            asgr_pkg::OP_PUT:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_PUT;
                e_row  = head_reg;
                e_col  = col_reg;
                e_char = cmd.blank ? asgr_pkg::BYTE_SPACE : byte_reg;
                e_attr = cmd.blank ? 6'd0 : attr_reg;
            end
            asgr_pkg::OP_EOL:
            begin
                emit   = 1'b1;
                e_kind = asgr_pkg::KIND_EOL;
                e_row  = head_reg;
                e_col  = col_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign row_ext  = ROW_EXT_W'(e_row);
    assign live_ext = LIV_EXT_W'(e_live);

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            param_store[pcount_reg[IDX_W-1:0]] <= store_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= in_byte;
        end
        if (emit)
        begin
            out_data_reg <= {1'b0, e_idx, live_ext[8:0], e_attr, e_char, e_col, row_ext[7:0]};
            out_user_reg <= e_kind;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= asgr_pkg::COLS_RESET;
            phase_reg  <= asgr_pkg::PH_PLAIN;
            pcount_reg <= '0;
            pvalue_reg <= 8'd0;
            ppend_reg  <= 1'b0;
            sidx_reg   <= '0;
            attr_reg   <= 6'd0;
            head_reg   <= '0;
            live_reg   <= LIVE_W'(1);
            col_reg    <= 8'd0;
            capt_reg   <= 1'b0;
            plen_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cols_reg <= cfg_data;
            end
            if (store_we)
            begin
                pcount_reg <= pcount_reg + CNT_W'(1);
            end
            unique case (cmd.op)
                asgr_pkg::OP_SILENT:
                begin
                    if (capt_reg)
                    begin
                        // dropped: path full
                    end
                    else if (byte_reg == asgr_pkg::BYTE_MARK)
                    begin
                        capt_reg <= 1'b1;
                        plen_reg <= '0;
                    end
                    else if (phase_reg == asgr_pkg::PH_ESC)
                    begin
                        if (byte_reg == asgr_pkg::BYTE_LBRACKET)
                        begin
                            phase_reg  <= asgr_pkg::PH_CSI;
                            pcount_reg <= '0;
                            ppend_reg  <= 1'b0;
                            pvalue_reg <= 8'd0;
                        end
                        else
                        begin
                            phase_reg <= asgr_pkg::PH_PLAIN;
                        end
                    end
                    else if (phase_reg == asgr_pkg::PH_CSI)
                    begin
                        if (is_digit)
                        begin
                            pvalue_reg <= digit_sat;
                            ppend_reg  <= 1'b1;
                        end
                        else if (byte_reg == asgr_pkg::BYTE_SEMI)
                        begin
                            ppend_reg  <= 1'b0;
                            pvalue_reg <= 8'd0;
                        end
                        else if (is_final)
                        begin
                            phase_reg <= asgr_pkg::PH_PLAIN;
                        end
                    end
                    else if (byte_reg == asgr_pkg::BYTE_ESC)
                    begin
                        phase_reg <= asgr_pkg::PH_ESC;
                    end
                    else if (byte_reg == asgr_pkg::BYTE_CR)
                    begin
                        col_reg <= 8'd0;
                    end
                end
                asgr_pkg::OP_SGR_START:
                begin
                    phase_reg <= asgr_pkg::PH_PLAIN;
                    sidx_reg  <= '0;
                end
                asgr_pkg::OP_SGR_STEP:
                begin
                    attr_reg <= (pcount_reg == '0) ? 6'd0 : attr_applied;
                    sidx_reg <= sidx_reg + IDX_W'(1);
                end
                asgr_pkg::OP_PATH_BYTE:
                begin
                    plen_reg <= plen_reg + PATH_W'(1);
                end
                asgr_pkg::OP_PATH_DONE:
                begin
                    capt_reg <= 1'b0;
                end
                asgr_pkg::OP_NEW_ROW:
                begin
                    head_reg <= head_inc;
                    live_reg <= live_inc;
                    col_reg  <= 8'd0;
                end
                asgr_pkg::OP_CLEAR_ALL:
                begin
                    head_reg <= '0;
                    live_reg <= LIVE_W'(1);
                    col_reg  <= 8'd0;
                end
                asgr_pkg::OP_BACKSPACE:
                begin
                    col_reg <= col_reg - 8'd1;
                end
                asgr_pkg::OP_PUT:
                begin
                    col_reg <= col_reg + 8'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == asgr_pkg::OP_PUT || cmd.op == asgr_pkg::OP_EOL
         || cmd.op == asgr_pkg::OP_NEW_ROW || cmd.op == asgr_pkg::OP_CLEAR_ALL
         || cmd.op == asgr_pkg::OP_BACKSPACE || cmd.op == asgr_pkg::OP_PATH_BYTE
         || cmd.op == asgr_pkg::OP_PATH_DONE) |-> sts.out_free)
        else $error("result issued while output register is occupied");

    a_col_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= 8'(MAX_COLUMNS))
        else $error("cursor past maximum column");

    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg != '0 && live_reg <= LIVE_W'(RING_ROWS))
        else $error("live row count out of range");

    a_pcount_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= CNT_W'(SGR_SLOTS))
        else $error("parameter count past store depth");

    a_clear_resets_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == asgr_pkg::OP_CLEAR_ALL |=> head_reg == '0 && live_reg == LIVE_W'(1))
        else $error("clear did not reset the ring");
`endif

endmodule

`default_nettype wire

FILE: rtl/ansi_sgr_transcript_writer.sv
`default_nettype none
// Flow: a byte is taken while the sequencer is idle and decoded from its
// held copy; its results enter the output register at most one per cycle,
// while the output register has room. No new byte is taken until the last
// result of the current one is issued; a tab writes blank cells up to its
// tab stop and an SGR steps through the stored parameters one by one.
// Reset: asynchronous, active low; clears parser, ring and output valid.
// ----------------------------------------------------------------------------
// ansi_sgr_transcript_writer
// Turns a terminal output byte stream into cell, row and path write commands
// for a ring of attributed text rows, tracking SGR colour and weight.
// ----------------------------------------------------------------------------
module ansi_sgr_transcript_writer #(
    parameter int RING_ROWS   = 256,
    parameter int MAX_COLUMNS = 220,
    parameter int PATH_BYTES  = 192,
    parameter int SGR_SLOTS   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,       // columns_in_use
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] row_slot, [15:8] column, [23:16] char_code, [29:24] cell_attr,
    // [38:30] rows_held, [46:39] path_index, [47] zero
    output logic [47:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // [2:0] kind
    output logic             m_axis_tlast
);

    asgr_pkg::cmd_t cmd;
    asgr_pkg::sts_t sts;
    logic           in_fire;
    logic           in_ready;

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;
    assign cfg_ready     = 1'b1;

    asgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asgr_dp #(
        .RING_ROWS   (RING_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .PATH_BYTES  (PATH_BYTES),
        .SGR_SLOTS   (SGR_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ansi_sgr_transcript_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ansi_sgr_transcript_writer
// Self-checking bench for the SGR transcript writer. Byte streams are fed
// through the input stream port, and every write command that comes out is
// compared field by field against a cycle-free predictor of the row ring,
// cursor, escape parser and path capture. Directed tests cover the control
// bytes, SGR codes, escape corner cases, path capture, column limits and ring
// wrap. A long random stream follows, mostly under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_transcript_writer;
    import asgr_pkg::*;

    localparam int RING_ROWS    = 256;
    localparam int MAX_COLUMNS  = 220;
    localparam int PATH_BYTES   = 192;
    localparam int SGR_SLOTS    = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  row_slot;
        logic [7:0]  column;
        logic [7:0]  char_code;
        logic [5:0]  cell_attr;
        logic [8:0]  rows_held;
        logic [7:0]  path_index;
        logic        last;
    } row_cmd_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted state of the writer
    logic [7:0]  cols_reg      = COLS_RESET;
    phase_t      esc_phase     = PH_PLAIN;
    logic [7:0]  param_store [SGR_SLOTS];
    int unsigned param_count   = 0;
    logic [7:0]  param_value   = '0;
    logic        param_pending = 1'b0;
    logic [5:0]  current_attr  = '0;
    logic [7:0]  head_slot     = '0;
    logic [8:0]  live_rows     = 9'd1;
    logic [7:0]  cursor_col    = '0;
    logic        in_path       = 1'b0;
    logic [7:0]  path_len      = '0;

    row_cmd_t    byte_cmds[$];
    row_cmd_t    cmds_due[$];

    int          error_count   = 0;
    int          bytes_sent    = 0;
    int          cmds_checked  = 0;
    int          cfg_writes    = 0;
    int          cycle_count   = 0;
    int          hold_request  = 0;
    bit          send_gaps     = 1'b1;
    bit          sink_gaps     = 1'b1;

    ansi_sgr_transcript_writer #(
        .RING_ROWS   (RING_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .PATH_BYTES  (PATH_BYTES),
        .SGR_SLOTS   (SGR_SLOTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("[ansi_sgr_transcript_writer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] row_limit();
        if (cols_reg < MIN_COLUMNS)
            return MIN_COLUMNS;
        if (cols_reg > MAX_COLUMNS)
            return 8'(MAX_COLUMNS);
        return cols_reg;
    endfunction

    function automatic void add_cmd(kind_t k, logic [7:0] slot, logic [7:0] col,
                                    logic [7:0] ch, logic [5:0] attr,
                                    logic [7:0] idx);
        row_cmd_t c;
        c.kind       = k;
        c.row_slot   = slot;
        c.column     = col;
        c.char_code  = ch;
        c.cell_attr  = attr;
        c.rows_held  = live_rows;
        c.path_index = idx;
        c.last       = 1'b0;
        byte_cmds.push_back(c);
    endfunction

    function automatic void start_row();
        head_slot = 8'((int'(head_slot) + 1) % RING_ROWS);
        if (live_rows < RING_ROWS)
            live_rows++;
        cursor_col = '0;
        add_cmd(KIND_NEW_ROW, head_slot, '0, '0, '0, '0);
    endfunction

    function automatic void apply_sgr_params();
        logic [7:0] p;
        if (param_pending && param_count < SGR_SLOTS)
        begin
            param_store[param_count] = param_value;
            param_count++;
        end
        if (param_count == 0)
        begin
            current_attr = '0;
            return;
        end
        for (int i = 0; i < param_count; i++)
        begin
            p = param_store[i];
            if (p == SGR_RESET)
                current_attr = '0;
            else if (p == SGR_BOLD)
                current_attr |= ATTR_BOLD;
            else if (p == SGR_NORMAL)
                current_attr &= ~ATTR_BOLD;
            else if (p >= SGR_FG_LO && p <= SGR_FG_HI)
                current_attr = (current_attr & ATTR_BOLD) | 6'(p - SGR_FG_BASE);
            else if (p >= SGR_BR_LO && p <= SGR_BR_HI)
                current_attr = (current_attr & ATTR_BOLD) | ATTR_BRIGHT
                               | 6'(p - SGR_BR_BASE);
            else if (p == SGR_FG_DEF)
                current_attr &= ATTR_BOLD;
        end
    endfunction

    // Advance the predicted state by one accepted byte and queue its commands
    function automatic void predict_writer(logic [7:0] b);
        logic [7:0] lim;
        int         stop;
        int         acc;
        lim = row_limit();
        byte_cmds.delete();
        if (in_path)
        begin
            if (b == BYTE_LF)
            begin
                in_path = 1'b0;
                add_cmd(KIND_PATH_DONE, '0, '0, '0, '0, path_len);
            end
            else if (path_len < PATH_BYTES - 1)
            begin
                add_cmd(KIND_PATH_BYTE, '0, '0, b, '0, path_len);
                path_len++;
            end
        end
        else if (b == BYTE_MARK)
        begin
            in_path  = 1'b1;
            path_len = '0;
        end
        else if (esc_phase == PH_ESC)
        begin
            if (b == BYTE_LBRACKET)
            begin
                esc_phase     = PH_CSI;
                param_count   = 0;
                param_pending = 1'b0;
                param_value   = '0;
            end
            else
                esc_phase = PH_PLAIN;
        end
        else if (esc_phase == PH_CSI)
        begin
            if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9)
            begin
                acc = (param_pending ? int'(param_value) : 0) * 10
                      + int'(b - BYTE_DIGIT_0);
                param_value   = (acc > PARAM_MAX) ? PARAM_MAX : 8'(acc);
                param_pending = 1'b1;
            end
            else if (b == BYTE_SEMI)
            begin
                if (param_count < SGR_SLOTS)
                begin
                    param_store[param_count] = param_pending ? param_value : 8'd0;
                    param_count++;
                end
                param_pending = 1'b0;
                param_value   = '0;
            end
            else if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI)
            begin
                if (b == BYTE_SGR_M)
                    apply_sgr_params();
                esc_phase = PH_PLAIN;
            end
        end
        else if (b == BYTE_ESC)
            esc_phase = PH_ESC;
        else if (b == BYTE_LF)
            start_row();
        else if (b == BYTE_CR)
            cursor_col = '0;
        else if (b == BYTE_TAB)
        begin
            stop = ((int'(cursor_col) >> TAB_BITS) + 1) << TAB_BITS;
            while (int'(cursor_col) < stop && cursor_col < lim)
            begin
                add_cmd(KIND_PUT, head_slot, cursor_col, BYTE_SPACE, '0, '0);
                cursor_col++;
            end
            add_cmd(KIND_EOL, head_slot, cursor_col, '0, '0, '0);
        end
        else if (b == BYTE_FF)
        begin
            head_slot  = '0;
            live_rows  = 9'd1;
            cursor_col = '0;
            add_cmd(KIND_CLEAR, '0, '0, '0, '0, '0);
        end
        else if (b == BYTE_BS)
        begin
            if (cursor_col > 0)
            begin
                cursor_col--;
                add_cmd(KIND_EOL, head_slot, cursor_col, '0, '0, '0);
            end
        end
        else if (b >= BYTE_SPACE)
        begin
            if (cursor_col >= lim)
                start_row();
            add_cmd(KIND_PUT, head_slot, cursor_col, b, current_attr, '0);
            cursor_col++;
            add_cmd(KIND_EOL, head_slot, cursor_col, '0, '0, '0);
        end
        if (byte_cmds.size() > 0)
            byte_cmds[byte_cmds.size() - 1].last = 1'b1;
        foreach (byte_cmds[i])
            cmds_due.push_back(byte_cmds[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_cmds
        row_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cmds_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected beat, expected none, actual kind %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = cmds_due.pop_front();
                check_field("kind",       want.kind,       m_axis_tuser);
                check_field("row_slot",   want.row_slot,   m_axis_tdata[7:0]);
                check_field("column",     want.column,     m_axis_tdata[15:8]);
                check_field("char_code",  want.char_code,  m_axis_tdata[23:16]);
                check_field("cell_attr",  want.cell_attr,  m_axis_tdata[29:24]);
                check_field("rows_held",  want.rows_held,  m_axis_tdata[38:30]);
                check_field("path_index", want.path_index, m_axis_tdata[46:39]);
                check_field("pad bit",    0,               m_axis_tdata[47]);
                check_field("last",       want.last,       m_axis_tlast);
                cmds_checked++;
            end
        end
    end

    // Receiver: random stalls, or a long counted hold when one is requested
    initial
    begin : sink_ready
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                hold_request = 0;
            end
            else if (sink_gaps && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        predict_writer(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s.getc(i));
    endtask

    task automatic send_csi(input string body);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_text(body);
    endtask

    // Drop valid, wait for every queued command, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (cmds_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_columns(input logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cols_reg = v;
        cfg_writes++;
    endtask

    function automatic int pick_sgr_code();
        case ($urandom_range(0, 9))
            0:       return SGR_RESET;
            1:       return SGR_BOLD;
            2:       return SGR_NORMAL;
            3:       return SGR_FG_DEF;
            4, 5:    return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            6, 7:    return $urandom_range(SGR_BR_LO, SGR_BR_HI);
            8:       return $urandom_range(0, 2999);
            default: return -1;   // empty parameter
        endcase
    endfunction

    task automatic send_random_chunk();
        int         pick;
        int         n;
        int         code;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    b = 8'($urandom_range(8'h7F, 8'hFF));
                else
                    b = 8'($urandom_range(BYTE_SPACE, BYTE_FINAL_HI));
                send_byte(b);
            end
        end
        else if (pick < 50)
        begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACKET);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
            begin
                if (k > 0)
                    send_byte(BYTE_SEMI);
                code = pick_sgr_code();
                if (code >= 0)
                    send_text($sformatf("%0d", code));
            end
            send_byte(BYTE_SGR_M);
        end
        else if (pick < 55)
        begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACKET);
            if ($urandom_range(0, 1))
                send_text($sformatf("%0d;%0d", $urandom_range(0, 400), $urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0)
            begin
                // intermediate or control byte, skipped inside the sequence
                b = 8'($urandom_range(0, BYTE_DIGIT_0 - 1));
                if (b == BYTE_MARK)
                    b = BYTE_SPACE;
                send_byte(b);
            end
            do b = 8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI));
            while (b == BYTE_SGR_M);
            send_byte(b);
        end
        else if (pick < 65)
            send_byte(BYTE_LF);
        else if (pick < 70)
            send_byte(BYTE_CR);
        else if (pick < 78)
            send_byte(BYTE_TAB);
        else if (pick < 84)
            send_byte(BYTE_BS);
        else if (pick < 88)
        begin
            send_byte(BYTE_MARK);
            n = $urandom_range(0, 20);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == BYTE_LF)
                    b = BYTE_SPACE;
                send_byte(b);
            end
            send_byte(BYTE_LF);
        end
        else if (pick < 90)
            send_byte(BYTE_FF);
        else if (pick < 93)
        begin
            send_byte(BYTE_ESC);
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_LBRACKET)
                b = BYTE_SPACE;
            send_byte(b);
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_controls_and_print();
        send_byte(8'h00);           // other control byte: dropped
        send_text("A");
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(BYTE_BS);
        send_byte(BYTE_CR);
        send_byte(BYTE_BS);         // at column zero: nothing
        send_byte(BYTE_TAB);
        send_text("x");
        send_byte(BYTE_TAB);
        send_byte(BYTE_LF);
        send_byte(BYTE_FF);
    endtask

    task automatic test_sgr_codes();
        send_csi("1;31m");
        send_text("a");
        send_csi("97m");
        send_text("b");
        send_csi("39;22m");
        send_text("c");
        send_csi("30;1;37;90;0;35m");
        send_text("d");
        send_csi("m");              // no parameters: reset
        send_text("e");
        send_csi("92;;m");          // empty parameters read as reset
        send_text("f");
        settle();
    endtask

    task automatic test_escape_corners();
        send_byte(BYTE_ESC);
        send_text("xy");            // byte after a lone escape is dropped
        send_csi("999;2H");         // other final byte, saturated parameter
        send_text("z");
        send_csi("1;2;3;4;5;6;7;8;32m");   // ninth parameter falls off
        send_text("g");
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_byte(8'h01);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LF);
        send_text(" 34m");
        send_text("h");
        send_csi("256;0m");
        send_text("i");
        settle();
    endtask

    task automatic test_path_capture();
        send_byte(BYTE_MARK);
        send_text("a/");
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_byte(BYTE_MARK);
        send_byte(BYTE_LF);
        send_byte(BYTE_MARK);
        send_byte(BYTE_LF);         // empty path
        send_text("q");
        settle();
    endtask

    task automatic test_path_overflow();
        logic [7:0] b;
        send_byte(BYTE_MARK);
        repeat (PATH_BYTES + 3)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_LF)
                b = BYTE_SPACE;
            send_byte(b);
        end
        send_byte(BYTE_LF);
        settle();
    endtask

    task automatic test_narrow_rows();
        write_columns(8'd0);        // clamps up to the minimum width
        send_byte(BYTE_CR);
        repeat (4) send_byte(BYTE_TAB);
        send_text("w");             // hard wrap
        send_byte(BYTE_BS);
        write_columns(MIN_COLUMNS);
        send_byte(BYTE_CR);
        send_text("0123456789abcdefghijkl");
        settle();
    endtask

    task automatic test_wide_rows();
        write_columns(8'd255);      // clamps down to the maximum width
        send_byte(BYTE_CR);
        repeat (MAX_COLUMNS / 8 + 2) send_byte(BYTE_TAB);
        send_text("W");
        write_columns(8'(MAX_COLUMNS));
        send_byte(BYTE_CR);
        repeat (MAX_COLUMNS / 8 + 1) send_byte(BYTE_TAB);
        send_text("Vv");
        settle();
    endtask

    task automatic test_ring_wrap();
        send_byte(BYTE_FF);
        repeat (RING_ROWS + 4) send_byte(BYTE_LF);
        send_text("r");
        send_byte(BYTE_FF);
        settle();
    endtask

    task automatic test_backpressure();
        send_gaps    = 1'b0;
        hold_request = 300;
        repeat (10)
        begin
            send_text("ab");
            send_byte(BYTE_TAB);
            send_byte(BYTE_LF);
        end
        settle();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [7:0] setting [4];
        int         target;
        setting[0] = 8'($urandom_range(MIN_COLUMNS, 40));
        setting[1] = 8'($urandom_range(0, 255));
        setting[2] = COLS_RESET;
        setting[3] = 8'($urandom_range(MIN_COLUMNS, MAX_COLUMNS));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_columns(setting[ph]);
            if (ph == 3)
            begin
                // run the last stretch at full rate on both sides
                send_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            target = bytes_sent + 65;
            while (bytes_sent < target)
                send_random_chunk();
        end
    endtask

    initial
    begin : run
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_controls_and_print();
        test_sgr_codes();
        test_escape_corners();
        test_path_capture();
        test_path_overflow();
        test_narrow_rows();
        test_wide_rows();
        test_ring_wrap();
        test_backpressure();
        test_random_stream();
        settle();
        $display("Run covered %0d stream bytes and %0d column settings;", bytes_sent, cfg_writes);
        $display("%0d write commands checked, %0d mismatches.", cmds_checked, error_count);
        if (error_count == 0)
            $display("[ansi_sgr_transcript_writer] OK");
        else
            $display("[ansi_sgr_transcript_writer] ERROR");
        $finish;
    end

endmodule
